### sv/csv_field_tokenizer_assert.svh
// assertion macros of the csv field tokenizer, used by the result queue
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define CFT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csv tokenizer assertion failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define CFT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csv tokenizer assertion failed");

`endif

### sv/csv_ftok_pkg.sv
// shared types and codes of the csv field tokenizer
`default_nettype none
package csv_ftok_pkg;

	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_EOL  = 2'd1;
	localparam logic [1:0] CMD_EOI  = 2'd2;

	localparam logic [1:0] KIND_BYTE       = 2'd0;
	localparam logic [1:0] KIND_FIELD_END  = 2'd1;
	localparam logic [1:0] KIND_RECORD_END = 2'd2;
	localparam logic [1:0] KIND_ERROR      = 2'd3;

	localparam logic [1:0] ERR_MISPLACED    = 2'd0;
	localparam logic [1:0] ERR_BAD_CLOSE    = 2'd1;
	localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

	localparam logic [1:0] REG_DELIMITER = 2'd0;
	localparam logic [1:0] REG_QUOTE     = 2'd1;
	localparam logic [1:0] REG_ESCAPE    = 2'd2;

	localparam logic [7:0] DELIMITER_RESET = 8'd44;
	localparam logic [7:0] QUOTE_RESET     = 8'd34;
	localparam logic [7:0] ESCAPE_RESET    = 8'd34;
	localparam logic [7:0] NEWLINE_CHAR    = 8'h0A;

	localparam int TRIM_PORT_W = 16;
	localparam int MAX_RES     = 3;
	localparam int FIFO_DEPTH  = 4;

	typedef struct packed {
		logic [7:0] delimiter_char;
		logic [7:0] quote_char;
		logic [7:0] escape_char;
	} cfg_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [7:0]             field_byte;
		logic [TRIM_PORT_W-1:0] trim_count;
		logic                   was_quoted;
		logic [1:0]             error_code;
		logic                   last;
	} result_t;

	// results of one item, handed from the parser to the result queue
	typedef struct packed {
		logic [1:0]                n;
		result_t [MAX_RES-1:0]     r;
	} push_t;

endpackage
`default_nettype wire

### sv/csv_ftok_core.sv
// parser state machine: turns one registered item into up to three results
`default_nettype none
module csv_ftok_core #(
	parameter int TRIM_COUNT_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire csv_ftok_pkg::cfg_t   cfg,
	input  wire logic                 go,
	input  wire logic [1:0]           command,
	input  wire logic [7:0]           text_byte,
	output csv_ftok_pkg::push_t       push
);
	import csv_ftok_pkg::*;

	localparam int CNT_W = (TRIM_COUNT_BITS > TRIM_PORT_W) ? TRIM_PORT_W : TRIM_COUNT_BITS;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef enum logic [2:0] {
		M_IDLE, M_FSTART, M_UNQ, M_QUO, M_QCLOSE, M_ESC, M_DROP, M_CONT
	} mode_t;

	mode_t                 mode_q, mode_d;
	cnt_t                  cnt_q, cnt_d;
	logic                  quoted_q, quoted_d;
	logic [1:0]            n_d;
	result_t [MAX_RES-1:0] r_d;
	logic                  run_field, run_eol;

	function automatic logic is_space(logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic result_t mk_res(logic [1:0] k, logic [7:0] d,
			logic [TRIM_PORT_W-1:0] t, logic q, logic [1:0] e);
		result_t x;
		x.kind       = k;
		x.field_byte = d;
		x.trim_count = t;
		x.was_quoted = q;
		x.error_code = e;
		x.last       = 1'b0;
		return x;
	endfunction

	// trailing whitespace tracking of unquoted fields, saturating
	function automatic cnt_t next_cnt(cnt_t c, logic q, logic [7:0] d);
		cnt_t x;
		x = c;
		if (!q) begin
			if (!is_space(d)) x = '0;
			else if (c != '1) x = c + cnt_t'(1);
		end
		return x;
	endfunction

	always_comb begin
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		quoted_d  = quoted_q;
		n_d       = 2'd0;
		r_d       = '0;
		run_field = 1'b0;
		run_eol   = 1'b0;

		case (command)
			CMD_BYTE: begin
				unique case (mode_d)
					M_IDLE, M_FSTART: begin
						cnt_d = '0;
						if (text_byte == cfg.quote_char) begin
							quoted_d = 1'b1;
							mode_d   = M_QUO;
						end else begin
							quoted_d  = 1'b0;
							mode_d    = M_UNQ;
							run_field = 1'b1;
						end
					end
					M_QCLOSE: begin
						if (text_byte == cfg.delimiter_char) begin
							r_d[n_d] = mk_res(KIND_FIELD_END, 8'h00,
								quoted_d ? '0 : TRIM_PORT_W'(cnt_d), quoted_d, ERR_MISPLACED);
							n_d    = n_d + 2'd1;
							mode_d = M_FSTART;
						end else begin
							// doubled quote is a literal quote only when quote equals escape
							if (!(cfg.quote_char == cfg.escape_char &&
									text_byte == cfg.quote_char)) begin
								r_d[n_d] = mk_res(KIND_ERROR, 8'h00, '0, 1'b0, ERR_BAD_CLOSE);
								n_d = n_d + 2'd1;
							end
							r_d[n_d] = mk_res(KIND_BYTE, text_byte, '0, 1'b0, ERR_MISPLACED);
							n_d    = n_d + 2'd1;
							cnt_d  = next_cnt(cnt_d, quoted_d, text_byte);
							mode_d = M_QUO;
						end
					end
					M_ESC: begin
						r_d[n_d] = mk_res(KIND_BYTE, text_byte, '0, 1'b0, ERR_MISPLACED);
						n_d    = n_d + 2'd1;
						cnt_d  = next_cnt(cnt_d, quoted_d, text_byte);
						mode_d = quoted_d ? M_QUO : M_UNQ;
					end
					M_DROP: begin
					end
					M_UNQ, M_QUO, M_CONT: begin
						mode_d    = quoted_d ? M_QUO : M_UNQ;
						run_field = 1'b1;
					end
				endcase
			end
			CMD_EOL: run_eol = 1'b1;
			CMD_EOI: run_eol = (mode_d != M_IDLE) && (mode_d != M_CONT);
			default: begin
			end
		endcase

		if (run_field) begin
			if (text_byte == cfg.quote_char) begin
				if (quoted_d) mode_d = M_QCLOSE;
				else begin
					r_d[n_d] = mk_res(KIND_ERROR, 8'h00, '0, 1'b0, ERR_MISPLACED);
					n_d    = n_d + 2'd1;
					mode_d = M_DROP;
				end
			end else if (text_byte == cfg.escape_char) begin
				mode_d = M_ESC;
			end else if (text_byte == cfg.delimiter_char && !quoted_d) begin
				r_d[n_d] = mk_res(KIND_FIELD_END, 8'h00, TRIM_PORT_W'(cnt_d), 1'b0,
					ERR_MISPLACED);
				n_d    = n_d + 2'd1;
				mode_d = M_FSTART;
			end else begin
				r_d[n_d] = mk_res(KIND_BYTE, text_byte, '0, 1'b0, ERR_MISPLACED);
				n_d   = n_d + 2'd1;
				cnt_d = next_cnt(cnt_d, quoted_d, text_byte);
			end
		end

		if (run_eol) begin
			unique case (mode_d)
				M_IDLE: begin
					// empty line: one empty unquoted field, then the record end
					r_d[n_d] = mk_res(KIND_FIELD_END, 8'h00, '0, 1'b0, ERR_MISPLACED);
					n_d = n_d + 2'd1;
					r_d[n_d] = mk_res(KIND_RECORD_END, 8'h00, '0, 1'b0, ERR_MISPLACED);
					n_d      = n_d + 2'd1;
					mode_d   = M_IDLE;
					quoted_d = 1'b0;
					cnt_d    = '0;
				end
				M_FSTART, M_DROP: begin
					r_d[n_d] = mk_res(KIND_RECORD_END, 8'h00, '0, 1'b0, ERR_MISPLACED);
					n_d      = n_d + 2'd1;
					mode_d   = M_IDLE;
					quoted_d = 1'b0;
					cnt_d    = '0;
				end
				M_ESC: begin
					r_d[n_d] = mk_res(KIND_BYTE, NEWLINE_CHAR, '0, 1'b0, ERR_MISPLACED);
					n_d    = n_d + 2'd1;
					cnt_d  = next_cnt(cnt_d, quoted_d, NEWLINE_CHAR);
					mode_d = M_CONT;
				end
				M_QCLOSE, M_UNQ, M_QUO, M_CONT: begin
					if (quoted_d && mode_d != M_QCLOSE) begin
						r_d[n_d] = mk_res(KIND_BYTE, NEWLINE_CHAR, '0, 1'b0, ERR_MISPLACED);
						n_d    = n_d + 2'd1;
						cnt_d  = next_cnt(cnt_d, quoted_d, NEWLINE_CHAR);
						mode_d = M_CONT;
					end else begin
						r_d[n_d] = mk_res(KIND_FIELD_END, 8'h00,
							quoted_d ? '0 : TRIM_PORT_W'(cnt_d), quoted_d, ERR_MISPLACED);
						n_d = n_d + 2'd1;
						r_d[n_d] = mk_res(KIND_RECORD_END, 8'h00, '0, 1'b0, ERR_MISPLACED);
						n_d      = n_d + 2'd1;
						mode_d   = M_IDLE;
						quoted_d = 1'b0;
						cnt_d    = '0;
					end
				end
			endcase
		end

		// end of input with a field still open across lines
		if (command == CMD_EOI && mode_d == M_CONT) begin
			r_d[n_d] = mk_res(KIND_ERROR, 8'h00, '0, 1'b0, ERR_UNTERMINATED);
			n_d      = n_d + 2'd1;
			mode_d   = M_IDLE;
			quoted_d = 1'b0;
			cnt_d    = '0;
		end

		if (n_d != 2'd0) r_d[n_d - 2'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			cnt_q    <= '0;
			quoted_q <= 1'b0;
		end else if (go) begin
			mode_q   <= mode_d;
			cnt_q    <= cnt_d;
			quoted_q <= quoted_d;
		end
	end

	assign push.n = go ? n_d : 2'd0;
	assign push.r = r_d;

endmodule
`default_nettype wire

### sv/csv_ftok_fifo.sv
// result queue: takes up to three results a cycle, hands out one
`default_nettype none
`include "csv_field_tokenizer_assert.svh"
module csv_ftok_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire csv_ftok_pkg::push_t   push,
	output logic                       room,
	output csv_ftok_pkg::result_t      head,
	output logic                       out_valid,
	input  wire logic                  out_ready
);
	import csv_ftok_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CW    = $clog2(FIFO_DEPTH + 1);

	result_t              mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]     wr_q, rd_q;
	logic [CW-1:0]        count_q;
	logic                 pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_q];
	// room for a full item's worth of results
	assign room      = (count_q <= CW'(FIFO_DEPTH - MAX_RES));

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (i < int'(push.n)) mem_q[wr_q + PTR_W'(i)] <= push.r[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.n);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

	`CFT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(FIFO_DEPTH))
	`CFT_ASSERT_IMP(a_push_room, push.n != 2'd0, room)
	`CFT_ASSERT_NXT(a_stall_hold, out_valid && !out_ready && push.n == 2'd0, $stable(count_q) && $stable(rd_q))

endmodule
`default_nettype wire

### sv/csv_field_tokenizer.sv
// Streaming CSV field tokenizer, one text byte or line mark per input item.
// Input channel in_valid/in_ready carries command (byte, end of line, end of
// input) and text_byte. Each accepted item yields zero to three results on
// the out_valid/out_ready channel, one result per handshake, the final one
// of an item flagged by last. Results are field bytes, field ends with the
// trailing whitespace count and quoted flag, record ends and errors.
// Config channel cfg_valid/cfg_ready writes delimiter (index 0), quote (1)
// and escape (2) characters; cfg_ready is always high, other indexes ignored.
// The first result of an item passes the input register, then the parser
// writes it into the result queue, which presents it on the output.
// Throughput: one item per cycle while each item yields at most one result
// and the receiver is ready; an item with k results takes k handshakes on
// the single result port behind a four-entry queue.
// A stalled receiver fills the queue; the parser then holds its item and
// in_ready drops until room for three results is free again.
// Reset clears the parser to idle between records, empties the queue and
// restores the default characters (comma, double quote, double quote).
`default_nettype none
module csv_field_tokenizer #(
	parameter int TRIM_COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  text_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       field_byte,
	output logic [15:0]      trim_count,
	output logic             was_quoted,
	output logic [1:0]       error_code,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import csv_ftok_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [1:0]  command_s1;
	logic [7:0]  text_byte_s1;
	logic        room, go, in_accept;
	push_t       push;
	result_t     head;

	assign cfg_ready = 1'b1;
	assign go        = valid_s1 && room;
	assign in_ready  = !valid_s1 || room;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_char <= DELIMITER_RESET;
			cfg_q.quote_char     <= QUOTE_RESET;
			cfg_q.escape_char    <= ESCAPE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DELIMITER: cfg_q.delimiter_char <= cfg_data;
				REG_QUOTE:     cfg_q.quote_char     <= cfg_data;
				REG_ESCAPE:    cfg_q.escape_char    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			command_s1   <= command;
			text_byte_s1 <= text_byte;
		end
	end

	csv_ftok_core #(
		.TRIM_COUNT_BITS(TRIM_COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.go        (go),
		.command   (command_s1),
		.text_byte (text_byte_s1),
		.push      (push)
	);

	csv_ftok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.head      (head),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	assign kind       = head.kind;
	assign field_byte = head.field_byte;
	assign trim_count = head.trim_count;
	assign was_quoted = head.was_quoted;
	assign error_code = head.error_code;
	assign last       = head.last;

endmodule
`default_nettype wire

### sim/tb_top.sv
// self-checking testbench of the csv field tokenizer
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import csv_ftok_pkg::*;

	localparam int TRIM_BITS = 16;
	localparam logic [15:0] TRIM_MAX = (TRIM_BITS >= 16) ? 16'hFFFF : 16'((1 << TRIM_BITS) - 1);
	localparam logic [1:0] CMD_UNDEF = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam int NUM_PHASES = 7;
	localparam int PHASE_ITEMS = 56;
	localparam int HOLD_PHASE = 2;
	localparam int PAUSE_PHASE = 3;
	localparam int HOLD_CYCLES = 200;
	localparam int TAIL_CYCLES = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int PRINT_CAP = 50;

	typedef enum logic [2:0] {
		PM_IDLE, PM_FSTART, PM_UNQ, PM_QUO, PM_QCLOSE, PM_ESC, PM_DROP, PM_CONT
	} pmode_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] b;
	} stim_t;

	typedef struct {
		stim_t          s;
		bit             fixed;
		int             n;
		result_t [2:0]  r;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [7:0]  text_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  field_byte;
	logic [15:0] trim_count;
	logic        was_quoted;
	logic [1:0]  error_code;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	csv_field_tokenizer #(
		.TRIM_COUNT_BITS(TRIM_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.text_byte  (text_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.field_byte (field_byte),
		.trim_count (trim_count),
		.was_quoted (was_quoted),
		.error_code (error_code),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// packed as delimiter, quote, escape
	cfg_t phase_chars [NUM_PHASES] = '{
		24'h2C2222, 24'h09275C, 24'h00FFFF, 24'hFF005C, 24'h3B225C, 24'h2C2C2C, 24'h7C5C22
	};

	// tokenizer state as the block should hold it
	cfg_t        chars;
	pmode_t      pmode;
	logic [15:0] ws_run;
	logic        in_quotes;
	result_t     pred_res [MAX_RES];
	int          pred_n;

	result_t pending_results [$];
	stim_t   stim_q [$];
	row_t    dir_rows [$];

	int  fail_count;
	int  items_sent;
	int  results_checked;
	int  phase_items;
	int  idle_cycles;
	int  rx_hold;
	int  rx_stall;
	bit  rx_calm;
	bit  tx_calm;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report(string msg);
		if (fail_count < PRINT_CAP)
			$display("mismatch: %s", msg);
		fail_count++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report($sformatf("result %0d %s got %0h want %0h", results_checked, name, got, want));
	endtask

	task automatic emit_result(logic [1:0] k, logic [7:0] b, logic [15:0] trim, logic q,
			logic [1:0] err);
		result_t r;
		r = '0;
		r.kind = k;
		r.field_byte = b;
		r.trim_count = trim;
		r.was_quoted = q;
		r.error_code = err;
		if (pred_n < MAX_RES) begin
			pred_res[pred_n] = r;
			pred_n++;
		end
	endtask

	task automatic put_byte(logic [7:0] b);
		emit_result(KIND_BYTE, b, 16'd0, 1'b0, 2'd0);
		if (!in_quotes) begin
			if (!(b == SPACE_CHAR || (b >= 8'h09 && b <= 8'h0D)))
				ws_run = '0;
			else if (ws_run < TRIM_MAX)
				ws_run++;
		end
	endtask

	task automatic end_field();
		emit_result(KIND_FIELD_END, 8'd0, in_quotes ? 16'd0 : ws_run, in_quotes, 2'd0);
	endtask

	task automatic go_idle();
		pmode = PM_IDLE;
		in_quotes = 1'b0;
		ws_run = '0;
	endtask

	task automatic end_record();
		emit_result(KIND_RECORD_END, 8'd0, 16'd0, 1'b0, 2'd0);
		go_idle();
	endtask

	// quote wins over escape, escape over delimiter
	task automatic in_field(logic [7:0] b);
		if (b == chars.quote_char) begin
			if (in_quotes) begin
				pmode = PM_QCLOSE;
			end else begin
				emit_result(KIND_ERROR, 8'd0, 16'd0, 1'b0, ERR_MISPLACED);
				pmode = PM_DROP;
			end
		end else if (b == chars.escape_char) begin
			pmode = PM_ESC;
		end else if (b == chars.delimiter_char && !in_quotes) begin
			end_field();
			pmode = PM_FSTART;
		end else begin
			put_byte(b);
		end
	endtask

	task automatic line_end();
		case (pmode)
			PM_IDLE: begin
				in_quotes = 1'b0;
				ws_run = '0;
				end_field();
				end_record();
			end
			PM_FSTART, PM_DROP: begin
				end_record();
			end
			PM_QCLOSE: begin
				end_field();
				end_record();
			end
			PM_ESC: begin
				put_byte(NEWLINE_CHAR);
				pmode = PM_CONT;
			end
			default: begin
				if (in_quotes) begin
					put_byte(NEWLINE_CHAR);
					pmode = PM_CONT;
				end else begin
					end_field();
					end_record();
				end
			end
		endcase
	endtask

	task automatic tokenize_item(logic [1:0] c, logic [7:0] b);
		pred_n = 0;
		case (c)
			CMD_BYTE: begin
				case (pmode)
					PM_IDLE, PM_FSTART: begin
						ws_run = '0;
						if (b == chars.quote_char) begin
							in_quotes = 1'b1;
							pmode = PM_QUO;
						end else begin
							in_quotes = 1'b0;
							pmode = PM_UNQ;
							in_field(b);
						end
					end
					PM_QCLOSE: begin
						if (b == chars.delimiter_char) begin
							end_field();
							pmode = PM_FSTART;
						end else begin
							if (!(chars.quote_char == chars.escape_char && b == chars.quote_char))
								emit_result(KIND_ERROR, 8'd0, 16'd0, 1'b0, ERR_BAD_CLOSE);
							put_byte(b);
							pmode = PM_QUO;
						end
					end
					PM_ESC: begin
						put_byte(b);
						pmode = in_quotes ? PM_QUO : PM_UNQ;
					end
					PM_DROP: begin
					end
					default: begin
						pmode = in_quotes ? PM_QUO : PM_UNQ;
						in_field(b);
					end
				endcase
			end
			CMD_EOL: begin
				line_end();
			end
			CMD_EOI: begin
				if (pmode != PM_IDLE && pmode != PM_CONT)
					line_end();
				if (pmode == PM_CONT) begin
					emit_result(KIND_ERROR, 8'd0, 16'd0, 1'b0, ERR_UNTERMINATED);
					go_idle();
				end
			end
			default: begin
			end
		endcase
		if (pred_n > 0)
			pred_res[pred_n-1].last = 1'b1;
	endtask

	function automatic result_t mk(logic [1:0] k, logic [1:0] err, logic lst);
		result_t r;
		r = '0;
		r.kind = k;
		r.error_code = err;
		r.last = lst;
		return r;
	endfunction

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// skewed toward the configured special characters and whitespace
	function automatic logic [7:0] rand_text();
		int r;
		int w;
		r = $urandom_range(0, 99);
		w = $urandom_range(0, 5);
		if (r < 10)
			return chars.delimiter_char;
		if (r < 18)
			return chars.quote_char;
		if (r < 24)
			return chars.escape_char;
		if (r < 40)
			return (w == 5) ? SPACE_CHAR : 8'(9 + w);
		if (r < 60)
			return 8'($urandom_range(97, 122));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_stim(logic [1:0] c, logic [7:0] b);
		stim_t s;
		s.cmd = c;
		s.b = b;
		stim_q.insert(stim_q.size(), s);
		if (c != CMD_UNDEF)
			phase_items++;
	endtask

	task automatic add_row(logic [1:0] c, logic [7:0] b);
		row_t row;
		row.s.cmd = c;
		row.s.b = b;
		row.fixed = 1'b0;
		row.n = 0;
		row.r = '0;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic add_fixed(logic [1:0] c, logic [7:0] b, int n, result_t r0, result_t r1);
		row_t row;
		row.s.cmd = c;
		row.s.b = b;
		row.fixed = 1'b1;
		row.n = n;
		row.r = '0;
		row.r[0] = r0;
		row.r[1] = r1;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// a record of plain and quoted fields with random content
	task automatic gen_record();
		int n_fields;
		int len;
		int r;
		logic [7:0] b;
		logic q_is_e;
		q_is_e = (chars.quote_char == chars.escape_char);
		n_fields = $urandom_range(1, 4);
		for (int f = 0; f < n_fields; f++) begin
			if (f > 0)
				push_stim(CMD_BYTE, chars.delimiter_char);
			len = $urandom_range(0, 6);
			if ($urandom_range(0, 2) == 0) begin
				push_stim(CMD_BYTE, chars.quote_char);
				for (int i = 0; i < len; i++) begin
					b = rand_text();
					if ($urandom_range(0, 15) == 0) begin
						push_stim(CMD_EOL, 8'd0);
					end else if (b == chars.quote_char && q_is_e) begin
						push_stim(CMD_BYTE, b);
						push_stim(CMD_BYTE, b);
					end else if (b == chars.quote_char || b == chars.escape_char) begin
						push_stim(CMD_BYTE, chars.escape_char);
						push_stim(CMD_BYTE, b);
					end else begin
						push_stim(CMD_BYTE, b);
					end
				end
				push_stim(CMD_BYTE, chars.quote_char);
			end else begin
				for (int i = 0; i < len; i++) begin
					b = rand_text();
					if (!q_is_e && $urandom_range(0, 15) == 0) begin
						// line continuation
						push_stim(CMD_BYTE, chars.escape_char);
						push_stim(CMD_EOL, 8'd0);
					end else if (b == chars.quote_char || b == chars.escape_char ||
							b == chars.delimiter_char) begin
						push_stim(CMD_BYTE, q_is_e ? 8'h6B : chars.escape_char);
						if (!q_is_e)
							push_stim(CMD_BYTE, b);
					end else begin
						push_stim(CMD_BYTE, b);
					end
				end
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 5)) push_stim(CMD_BYTE, SPACE_CHAR);
			end
		end
		r = $urandom_range(0, 9);
		if (r < 7) begin
			push_stim(CMD_EOL, 8'd0);
		end else if (r == 7) begin
			push_stim(CMD_EOI, 8'd0);
		end else if (r == 8) begin
			push_stim(CMD_BYTE, chars.delimiter_char);
			push_stim(CMD_EOL, 8'd0);
		end else begin
			push_stim(CMD_EOL, 8'd0);
			push_stim(CMD_EOI, 8'd0);
		end
	endtask

	task automatic gen_noise();
		int len;
		int r;
		len = $urandom_range(1, 12);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 78)
				push_stim(CMD_BYTE, rand_text());
			else if (r < 88)
				push_stim(CMD_EOL, 8'($urandom_range(0, 255)));
			else if (r < 94)
				push_stim(CMD_EOI, 8'($urandom_range(0, 255)));
			else if (r < 97)
				push_stim(CMD_UNDEF, 8'($urandom_range(0, 255)));
			else
				push_stim(CMD_BYTE, 8'($urandom_range(0, 255)));
		end
		push_stim(CMD_EOL, 8'd0);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DELIMITER: chars.delimiter_char = d;
			REG_QUOTE:     chars.quote_char = d;
			REG_ESCAPE:    chars.escape_char = d;
			default: begin
			end
		endcase
	endtask

	task automatic load_chars(cfg_t c, bit stray);
		write_reg(REG_DELIMITER, c.delimiter_char);
		write_reg(REG_QUOTE, c.quote_char);
		write_reg(REG_ESCAPE, c.escape_char);
		if (stray)
			write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
		cfg_valid <= 1'b0;
	endtask

	// valid stays high across back-to-back items, lowered only for a gap
	task automatic send_item(stim_t s, int gap, bit use_fix, int fix_n, result_t [2:0] fix_r);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= s.cmd;
		text_byte <= s.b;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		tokenize_item(s.cmd, s.b);
		if (use_fix) begin
			for (int i = 0; i < fix_n; i++)
				pending_results.insert(pending_results.size(), fix_r[i]);
		end else begin
			for (int i = 0; i < pred_n; i++)
				pending_results.insert(pending_results.size(), pred_res[i]);
		end
	endtask

	// stop offering items, wait for every result and let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected, kind %0d",
					results_checked, kind));
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 16'(kind), 16'(want.kind));
				check_field("field_byte", 16'(field_byte), 16'(want.field_byte));
				check_field("trim_count", trim_count, want.trim_count);
				check_field("was_quoted", 16'(was_quoted), 16'(want.was_quoted));
				check_field("error_code", 16'(error_code), 16'(want.error_code));
				check_field("last", 16'(last), 16'(want.last));
			end
			results_checked++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", idle_cycles);
				$display("[csv_field_tokenizer] ERROR");
				$finish;
			end
		end
	end

	// receiver: random stalls, and one long hold-off on request
	initial begin
		rx_stall = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				rx_stall = rx_hold;
				rx_hold = 0;
			end
			if (rx_stall > 0) begin
				out_ready <= 1'b0;
				rx_stall--;
			end else begin
				out_ready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					rx_stall = pick_gap(1'b0);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_BYTE;
		text_byte = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = REG_DELIMITER;
		cfg_data = 8'd0;
		fail_count = 0;
		items_sent = 0;
		results_checked = 0;
		idle_cycles = 0;
		rx_hold = 0;
		rx_calm = 1'b0;
		tx_calm = 1'b0;
		chars = {DELIMITER_RESET, QUOTE_RESET, ESCAPE_RESET};
		go_idle();

		// directed cases under the reset characters
		add_fixed(CMD_EOL, 8'd0, 2, mk(KIND_FIELD_END, 2'd0, 1'b0), mk(KIND_RECORD_END, 2'd0, 1'b1));
		add_fixed(CMD_EOI, 8'd0, 0, '0, '0);
		add_fixed(CMD_UNDEF, 8'hFF, 0, '0, '0);
		add_row(CMD_BYTE, 8'h00);
		add_row(CMD_BYTE, 8'hFF);
		add_row(CMD_BYTE, SPACE_CHAR);
		add_row(CMD_BYTE, DELIMITER_RESET);
		add_row(CMD_BYTE, DELIMITER_RESET);
		add_row(CMD_BYTE, QUOTE_RESET);
		add_row(CMD_BYTE, DELIMITER_RESET);
		add_row(CMD_BYTE, QUOTE_RESET);
		add_row(CMD_BYTE, QUOTE_RESET);
		add_row(CMD_BYTE, QUOTE_RESET);
		add_row(CMD_BYTE, "x");
		add_row(CMD_BYTE, QUOTE_RESET);
		add_row(CMD_BYTE, DELIMITER_RESET);
		add_fixed(CMD_EOL, 8'd0, 1, mk(KIND_RECORD_END, 2'd0, 1'b1), '0);
		add_row(CMD_BYTE, "a");
		add_fixed(CMD_BYTE, QUOTE_RESET, 1, mk(KIND_ERROR, ERR_MISPLACED, 1'b1), '0);
		add_fixed(CMD_BYTE, "b", 0, '0, '0);
		add_fixed(CMD_EOL, 8'd0, 1, mk(KIND_RECORD_END, 2'd0, 1'b1), '0);
		add_row(CMD_BYTE, QUOTE_RESET);
		add_row(CMD_EOL, 8'd0);
		add_fixed(CMD_EOI, 8'd0, 1, mk(KIND_ERROR, ERR_UNTERMINATED, 1'b1), '0);
		add_row(CMD_BYTE, "z");
		add_row(CMD_EOI, 8'd0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].s, pick_gap(1'b0), dir_rows[i].fixed, dir_rows[i].n,
				dir_rows[i].r);
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			rx_calm = (p == 1);
			tx_calm = (p == 1 || p == 4);
			load_chars(phase_chars[p], p == PAUSE_PHASE);
			phase_items = 0;
			stim_q.delete();
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) == 0)
					gen_noise();
				else
					gen_record();
			end
			foreach (stim_q[i]) begin
				if (i == stim_q.size() / 2) begin
					// hold phase: block fills up while the receiver holds off; pause phase: block settles first
					if (p == HOLD_PHASE)
						rx_hold = HOLD_CYCLES;
					if (p == PAUSE_PHASE)
						settle();
				end
				send_item(stim_q[i], pick_gap(tx_calm), 1'b0, 0, '0);
			end
			settle();
		end

		if (pending_results.size() != 0)
			report($sformatf("%0d expected results never arrived", pending_results.size()));
		$display("covered %0d items over %0d character settings plus directed cases,",
			items_sent, NUM_PHASES);
		$display("with %0d results checked under random stalls on both sides", results_checked);
		if (fail_count == 0)
			$display("[csv_field_tokenizer] OK");
		else
			$display("[csv_field_tokenizer] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
